[rtl/fjr_pkg.sv]
// Package: shared types, register indexes, defaults and helpers for the feeder jam recovery block.
package fjr_pkg;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_REVERSE  = 2'd1,
    PH_RECOVERY = 2'd2,
    PH_LOCKED   = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    REG_MIN_COMMAND_SPEED    = 3'd0,
    REG_STALL_SPEED_LIMIT    = 3'd1,
    REG_STALL_CURRENT_LIMIT  = 3'd2,
    REG_STARTUP_IGNORE_TICKS = 3'd3,
    REG_DETECT_TICKS         = 3'd4,
    REG_REVERSE_TICKS        = 3'd5,
    REG_RECOVERY_TICKS       = 3'd6,
    REG_MAX_RETRIES          = 3'd7
  } reg_idx_t;

  localparam int REVERSE_SPEED_DEF     = 2560;
  localparam int DIRECTION_DEF         = 1;
  localparam int CLEAN_RESET_TICKS_DEF = 500;

  localparam logic [7:0] RETRY_SAT = 8'd255;

  localparam logic [14:0] MIN_COMMAND_SPEED_RST    = 15'd256;
  localparam logic [14:0] STALL_SPEED_LIMIT_RST    = 15'd128;
  localparam logic [14:0] STALL_CURRENT_LIMIT_RST  = 15'd8000;
  localparam logic [15:0] STARTUP_IGNORE_TICKS_RST = 16'd100;
  localparam logic [15:0] DETECT_TICKS_RST         = 16'd50;
  localparam logic [15:0] REVERSE_TICKS_RST        = 16'd100;
  localparam logic [15:0] RECOVERY_TICKS_RST       = 16'd100;
  localparam logic [7:0]  MAX_RETRIES_RST          = 8'd3;

  localparam logic [15:0] CUR_SAT = 16'd32767;

  typedef struct packed {
    logic [14:0] min_command_speed;
    logic [14:0] stall_speed_limit;
    logic [14:0] stall_current_limit;
    logic [15:0] startup_ignore_ticks;
    logic [15:0] detect_ticks;
    logic [15:0] reverse_ticks;
    logic [15:0] recovery_ticks;
    logic [7:0]  max_retries;
  } cfg_t;

  typedef struct packed {
    logic               mode;
    logic signed [15:0] forward_speed;
    logic signed [15:0] measured_speed;
    logic signed [15:0] motor_current;
    logic               measure_valid;
  } item_t;

  typedef struct packed {
    logic signed [15:0] speed_command;
    phase_t             phase;
    logic               clear_loop;
    logic [7:0]         retries;
  } result_t;

  // |v| as unsigned; -32768 gives 32768
  function automatic logic [15:0] mag16(input logic signed [15:0] v);
    logic [15:0] neg;
    neg = 16'(~v) + 16'd1;
    return v[15] ? neg : v;
  endfunction

endpackage

[rtl/fjr_if.sv]
// Interfaces: input item channel, result channel and register write channel.
interface fjr_item_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [15:0] forward_speed;
  logic signed [15:0] measured_speed;
  logic signed [15:0] motor_current;
  logic               measure_valid;

  modport source (output valid, mode, forward_speed, measured_speed, motor_current,
                  measure_valid, input ready);
  modport sink   (input valid, mode, forward_speed, measured_speed, motor_current,
                  measure_valid, output ready);
endinterface

interface fjr_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] speed_command;
  logic [1:0]         phase;
  logic               clear_loop;
  logic [7:0]         retries;

  modport source (output valid, speed_command, phase, clear_loop, retries, input ready);
  modport sink   (input valid, speed_command, phase, clear_loop, retries, output ready);
endinterface

interface fjr_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/fjr_cfg_regs.sv]
// Configuration register file with reset defaults.
module fjr_cfg_regs
  import fjr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  fjr_cfg_if.sink   cfg,
  output cfg_t      regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.min_command_speed    <= MIN_COMMAND_SPEED_RST;
      regs.stall_speed_limit    <= STALL_SPEED_LIMIT_RST;
      regs.stall_current_limit  <= STALL_CURRENT_LIMIT_RST;
      regs.startup_ignore_ticks <= STARTUP_IGNORE_TICKS_RST;
      regs.detect_ticks         <= DETECT_TICKS_RST;
      regs.reverse_ticks        <= REVERSE_TICKS_RST;
      regs.recovery_ticks       <= RECOVERY_TICKS_RST;
      regs.max_retries          <= MAX_RETRIES_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (reg_idx_t'(cfg.index))
        REG_MIN_COMMAND_SPEED:    regs.min_command_speed    <= cfg.data[14:0];
        REG_STALL_SPEED_LIMIT:    regs.stall_speed_limit    <= cfg.data[14:0];
        REG_STALL_CURRENT_LIMIT:  regs.stall_current_limit  <= cfg.data[14:0];
        REG_STARTUP_IGNORE_TICKS: regs.startup_ignore_ticks <= cfg.data;
        REG_DETECT_TICKS:         regs.detect_ticks         <= cfg.data;
        REG_REVERSE_TICKS:        regs.reverse_ticks        <= cfg.data;
        REG_RECOVERY_TICKS:       regs.recovery_ticks       <= cfg.data;
        REG_MAX_RETRIES:          regs.max_retries          <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/fjr_core.sv]
// Jam detect / reverse / recovery state machine with its tick counters.
module fjr_core
  import fjr_pkg::*;
#(
  parameter int REVERSE_SPEED     = REVERSE_SPEED_DEF,
  parameter int DIRECTION         = DIRECTION_DEF,
  parameter int CLEAN_RESET_TICKS = CLEAN_RESET_TICKS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    adv,
  input  cfg_t    regs,
  input  item_t   item,
  output result_t res
);

  localparam logic signed [15:0] REV_CMD = 16'(-(REVERSE_SPEED * DIRECTION));
  localparam logic [15:0] CLEAN_LIM = 16'(CLEAN_RESET_TICKS);

  phase_t      phase_q, phase_next;
  logic [15:0] stall_count, stall_count_next;
  logic [15:0] reverse_count, reverse_count_next;
  logic [15:0] recovery_count, recovery_count_next;
  logic [15:0] startup_count, startup_count_next;
  logic [15:0] clean_count, clean_count_next;
  logic [7:0]  retry_count, retry_count_next;

  logic [15:0] fwd_mag, meas_mag, cur_mag_raw, cur_mag;
  logic        rst_tick, stalled;
  logic [15:0] stall_inc, clean_inc;
  logic signed [15:0] cmd;
  logic        clr;

  always_comb begin
    fwd_mag     = mag16(item.forward_speed);
    meas_mag    = mag16(item.measured_speed);
    cur_mag_raw = mag16(item.motor_current);
    cur_mag     = (cur_mag_raw > CUR_SAT) ? CUR_SAT : cur_mag_raw;
    rst_tick    = !item.mode || (fwd_mag < {1'b0, regs.min_command_speed});
    stalled     = item.measure_valid && (meas_mag < {1'b0, regs.stall_speed_limit})
                  && (cur_mag > {1'b0, regs.stall_current_limit});
    stall_inc   = (stall_count < regs.detect_ticks) ? stall_count + 16'd1 : stall_count;
    clean_inc   = (clean_count < CLEAN_LIM) ? clean_count + 16'd1 : clean_count;
  end

  // next state and counters
  always_comb begin
    phase_next          = phase_q;
    stall_count_next    = stall_count;
    reverse_count_next  = reverse_count;
    recovery_count_next = recovery_count;
    startup_count_next  = startup_count;
    clean_count_next    = clean_count;
    retry_count_next    = retry_count;
    if (rst_tick) begin
      phase_next          = PH_IDLE;
      stall_count_next    = '0;
      reverse_count_next  = '0;
      recovery_count_next = '0;
      startup_count_next  = '0;
      clean_count_next    = '0;
      retry_count_next    = '0;
    end else begin
      case (phase_q)
        PH_IDLE: begin
          if (startup_count < regs.startup_ignore_ticks) begin
            startup_count_next = startup_count + 16'd1;
            stall_count_next   = '0;
          end else if (stalled) begin
            clean_count_next = '0;
            stall_count_next = stall_inc;
            if (stall_inc >= regs.detect_ticks) begin
              stall_count_next    = '0;
              reverse_count_next  = '0;
              recovery_count_next = '0;
              startup_count_next  = '0;
              if (retry_count < RETRY_SAT) retry_count_next = retry_count + 8'd1;
              phase_next = PH_REVERSE;
            end
          end else begin
            stall_count_next = '0;
            clean_count_next = clean_inc;
            if (clean_inc >= CLEAN_LIM) retry_count_next = '0;
          end
        end
        PH_REVERSE: begin
          if (reverse_count < regs.reverse_ticks) begin
            reverse_count_next = reverse_count + 16'd1;
          end else begin
            reverse_count_next  = '0;
            recovery_count_next = '0;
            phase_next          = PH_RECOVERY;
          end
        end
        PH_RECOVERY: begin
          if (recovery_count < regs.recovery_ticks) begin
            recovery_count_next = recovery_count + 16'd1;
          end else if (retry_count >= regs.max_retries) begin
            phase_next = PH_LOCKED;
          end else begin
            recovery_count_next = '0;
            stall_count_next    = '0;
            startup_count_next  = '0;
            clean_count_next    = '0;
            phase_next          = PH_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  // outputs: every phase change and every reset tick clears the speed loop
  always_comb begin
    cmd = '0;
    clr = rst_tick || (phase_next != phase_q);
    if (!rst_tick) begin
      case (phase_q)
        PH_IDLE:    cmd = item.forward_speed;
        PH_REVERSE: cmd = REV_CMD;
        default:    cmd = '0;
      endcase
    end
    res.speed_command = cmd;
    res.phase         = phase_next;
    res.clear_loop    = clr;
    res.retries       = retry_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_q        <= PH_IDLE;
      stall_count    <= '0;
      reverse_count  <= '0;
      recovery_count <= '0;
      startup_count  <= '0;
      clean_count    <= '0;
      retry_count    <= '0;
    end else if (adv) begin
      phase_q        <= phase_next;
      stall_count    <= stall_count_next;
      reverse_count  <= reverse_count_next;
      recovery_count <= recovery_count_next;
      startup_count  <= startup_count_next;
      clean_count    <= clean_count_next;
      retry_count    <= retry_count_next;
    end
  end

  // locked is left only by a reset tick
  a_locked_holds: assert property (@(posedge clk) disable iff (rst)
    (adv && phase_q == PH_LOCKED && !rst_tick) |=> phase_q == PH_LOCKED)
    else $error("locked phase left without reset tick");

  // counters hold while no item advances
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(phase_q) && $stable(retry_count) && $stable(stall_count)))
    else $error("state changed without an item");

  // retry count only drops on a reset tick or a clean run in idle
  a_retry_drop: assert property (@(posedge clk) disable iff (rst)
    (adv && retry_count_next < retry_count) |-> (rst_tick || phase_q == PH_IDLE))
    else $error("retry count dropped outside idle");

  // stall count never exceeds the detect threshold after an update
  a_stall_bound: assert property (@(posedge clk) disable iff (rst)
    (adv && !rst_tick) |-> stall_count_next <= regs.detect_ticks
                           || stall_count_next == stall_count)
    else $error("stall count overran detect threshold");

endmodule

[rtl/feeder_jam_recovery_top.sv]
// Top level: input register, jam recovery core, result register and configuration port.
//
// Feeder jam recovery block.
// Channels (valid/ready, a request moves when both are high at a rising edge):
//   item   - one control tick: mode, forward_speed, measured_speed,
//            motor_current, measure_valid.
//   result - one result per tick: speed_command, phase, clear_loop, retries.
//   cfg    - register writes (index 0..7, data); always ready. Write only while
//            the block is idle with no request in flight.
// Path: a request taken in sits in the input register, is evaluated by the
// state machine and its result lands in the result register once that one is
// free or drained, visible from then on.
// Throughput: one request per clock while the result side takes results, set
// by the single state update per tick between the input and result registers.
// Stall: when the result side holds ready low, the result register holds, the
// input register fills and then item.ready drops; nothing is lost or repeated.
// Reset (rst, synchronous, active high): phase idle, all counters and the
// retry count cleared, registers back to their defaults, both stages empty.
module feeder_jam_recovery_top
  import fjr_pkg::*;
#(
  parameter int REVERSE_SPEED     = REVERSE_SPEED_DEF,
  parameter int DIRECTION         = DIRECTION_DEF,
  parameter int CLEAN_RESET_TICKS = CLEAN_RESET_TICKS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  fjr_item_if.sink      item,
  fjr_result_if.source  result,
  fjr_cfg_if.sink       cfg
);

  cfg_t    regs;
  item_t   item_q;
  logic    item_valid_q;
  result_t res_comb;
  result_t res_q;
  logic    res_valid_q;
  logic    adv;

  fjr_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // input stage moves into the result register when that one is free or drained
  assign adv        = item_valid_q && (!res_valid_q || result.ready);
  assign item.ready = !item_valid_q || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid_q <= 1'b0;
    end else if (item.ready) begin
      item_valid_q <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      item_q.mode           <= item.mode;
      item_q.forward_speed  <= item.forward_speed;
      item_q.measured_speed <= item.measured_speed;
      item_q.motor_current  <= item.motor_current;
      item_q.measure_valid  <= item.measure_valid;
    end
  end

  fjr_core #(
    .REVERSE_SPEED     (REVERSE_SPEED),
    .DIRECTION         (DIRECTION),
    .CLEAN_RESET_TICKS (CLEAN_RESET_TICKS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .regs (regs),
    .item (item_q),
    .res  (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid_q <= 1'b0;
    end else if (adv) begin
      res_valid_q <= 1'b1;
    end else if (result.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_q <= res_comb;
    end
  end

  assign result.valid         = res_valid_q;
  assign result.speed_command = res_q.speed_command;
  assign result.phase         = res_q.phase;
  assign result.clear_loop    = res_q.clear_loop;
  assign result.retries       = res_q.retries;

endmodule

[tb/sv/feeder_jam_recovery_top_tb.sv]
// Testbench for the feeder jam recovery block: directed and random ticks, self-checking.
`timescale 1ns / 100ps

module feeder_jam_recovery_top_tb;
  import fjr_pkg::*;

  // Receiver ready behavior, picked per test
  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_RANDOM,
    SINK_PATTERN
  } sink_style_t;

  logic clk;
  logic rst;

  fjr_item_if   item_bus();
  fjr_result_if result_bus();
  fjr_cfg_if    cfg_bus();

  feeder_jam_recovery_top DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .result (result_bus),
    .cfg    (cfg_bus)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the block: register settings and the jam state machine.
  // ---------------------------------------------------------------------------
  cfg_t   shadow_cfg;
  phase_t feed_phase;
  int     stall_run;
  int     rev_run;
  int     rec_run;
  int     start_run;
  int     clean_run;
  int     jam_count;

  // Expected results, oldest first
  result_t expected_results[$];

  // Bookkeeping
  int mismatch_count;
  int ticks_sent;
  int results_checked;
  int settings_loaded;
  int jams_seen;
  int lockouts_seen;
  int peak_retries;

  // Sender pacing and receiver stall control
  bit          src_gaps;
  int          burst_left;
  sink_style_t sink_style;
  logic [7:0]  sink_pattern;

  // Clock: 20 ns period
  initial clk = 1'b0;
  always begin
    #10 clk = ~clk;
  end

  // One line per mismatch, and count it
  task automatic flag_mismatch(string msg);
    mismatch_count++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  function automatic void clear_feeder_state();
    feed_phase = PH_IDLE;
    stall_run  = 0;
    rev_run    = 0;
    rec_run    = 0;
    start_run  = 0;
    clean_run  = 0;
    jam_count  = 0;
  endfunction

  // Next state and result for one accepted tick
  function automatic result_t advance_feeder(item_t t);
    result_t r;
    int      fwd_mag;
    int      spd_mag;
    int      cur_mag;
    bit      stalled;
    r.speed_command = '0;
    r.clear_loop    = 1'b0;
    fwd_mag = (t.forward_speed < 0) ? -int'(t.forward_speed) : int'(t.forward_speed);
    spd_mag = (t.measured_speed < 0) ? -int'(t.measured_speed) : int'(t.measured_speed);
    cur_mag = (t.motor_current < 0) ? -int'(t.motor_current) : int'(t.motor_current);
    if (cur_mag > 32767) cur_mag = 32767;
    stalled = t.measure_valid && (spd_mag < int'(shadow_cfg.stall_speed_limit)) &&
              (cur_mag > int'(shadow_cfg.stall_current_limit));

    if (!t.mode || fwd_mag < int'(shadow_cfg.min_command_speed)) begin
      // stop request or command too small: everything back to idle
      clear_feeder_state();
      r.clear_loop = 1'b1;
    end else begin
      case (feed_phase)
        PH_IDLE: begin
          r.speed_command = t.forward_speed;
          if (start_run < int'(shadow_cfg.startup_ignore_ticks)) begin
            start_run++;
            stall_run = 0;
          end else if (stalled) begin
            clean_run = 0;
            if (stall_run < int'(shadow_cfg.detect_ticks)) stall_run++;
            if (stall_run >= int'(shadow_cfg.detect_ticks)) begin
              stall_run  = 0;
              rev_run    = 0;
              rec_run    = 0;
              start_run  = 0;
              r.clear_loop = 1'b1;
              if (jam_count < int'(RETRY_SAT)) jam_count++;
              feed_phase = PH_REVERSE;
              jams_seen++;
            end
          end else begin
            stall_run = 0;
            if (clean_run < CLEAN_RESET_TICKS_DEF) clean_run++;
            if (clean_run >= CLEAN_RESET_TICKS_DEF) jam_count = 0;
          end
        end
        PH_REVERSE: begin
          r.speed_command = 16'(-REVERSE_SPEED_DEF * DIRECTION_DEF);
          if (rev_run < int'(shadow_cfg.reverse_ticks)) begin
            rev_run++;
          end else begin
            rev_run = 0;
            rec_run = 0;
            r.clear_loop = 1'b1;
            feed_phase = PH_RECOVERY;
          end
        end
        PH_RECOVERY: begin
          if (rec_run < int'(shadow_cfg.recovery_ticks)) begin
            rec_run++;
          end else if (jam_count >= int'(shadow_cfg.max_retries)) begin
            r.clear_loop = 1'b1;
            feed_phase = PH_LOCKED;
            lockouts_seen++;
          end else begin
            rec_run    = 0;
            stall_run  = 0;
            start_run  = 0;
            clean_run  = 0;
            r.clear_loop = 1'b1;
            feed_phase = PH_IDLE;
          end
        end
        default: begin
          // locked: zero drive until a stop request or a command below the minimum
        end
      endcase
    end

    if (jam_count > peak_retries) peak_retries = jam_count;
    r.phase   = feed_phase;
    r.retries = 8'(jam_count);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic item_t tick_of(bit m, int fwd, int meas, int cur, bit mv);
    item_t t;
    t.mode           = m;
    t.forward_speed  = 16'(fwd);
    t.measured_speed = 16'(meas);
    t.motor_current  = 16'(cur);
    t.measure_valid  = mv;
    return t;
  endfunction

  // Random tick shaped by the current settings. stall_pct picks a stalled
  // tick, otherwise a tick that is surely not stalled; noise_pct gives raw
  // random bits; stop_pct gives a stop request.
  function automatic item_t rand_tick(int stall_pct, int noise_pct, int stop_pct);
    item_t       t;
    logic [63:0] raw;
    int          m;
    int          spd_lim;
    int          cur_lim;
    raw = {$urandom, $urandom};
    t = raw[$bits(item_t)-1:0];
    if ($urandom_range(99) < noise_pct) return t;

    spd_lim = int'(shadow_cfg.stall_speed_limit);
    cur_lim = int'(shadow_cfg.stall_current_limit);
    t.mode = ($urandom_range(99) >= stop_pct);

    m = $urandom_range(32767, int'(shadow_cfg.min_command_speed));
    if ($urandom_range(1)) begin
      t.forward_speed = (m == 32767 && $urandom_range(1)) ? 16'sh8000 : 16'(-m);
    end else begin
      t.forward_speed = 16'(m);
    end

    if ($urandom_range(99) < stall_pct && spd_lim > 0 && cur_lim < 32767) begin
      t.measure_valid = 1'b1;
      m = $urandom_range(spd_lim - 1, 0);
      t.measured_speed = $urandom_range(1) ? 16'(-m) : 16'(m);
      m = $urandom_range(32767, cur_lim + 1);
      if ($urandom_range(1)) begin
        t.motor_current = (m == 32767 && $urandom_range(1)) ? 16'sh8000 : 16'(-m);
      end else begin
        t.motor_current = 16'(m);
      end
    end else begin
      // pick one way of not stalling
      case ($urandom_range(2))
        0: t.measure_valid = 1'b0;
        1: begin
          m = $urandom_range(32767, spd_lim);
          t.measured_speed = $urandom_range(1) ? 16'(-m) : 16'(m);
        end
        default: begin
          m = $urandom_range(cur_lim, 0);
          t.motor_current = $urandom_range(1) ? 16'(-m) : 16'(m);
        end
      endcase
    end
    return t;
  endfunction

  // Send one request; predict its result on acceptance, then maybe pause
  task automatic send_tick(item_t t);
    int gap;
    @(negedge clk);
    item_bus.valid          <= 1'b1;
    item_bus.mode           <= t.mode;
    item_bus.forward_speed  <= t.forward_speed;
    item_bus.measured_speed <= t.measured_speed;
    item_bus.motor_current  <= t.motor_current;
    item_bus.measure_valid  <= t.measure_valid;
    do @(posedge clk); while (!item_bus.ready);
    expected_results.push_back(advance_feeder(t));
    ticks_sent++;

    // burst pacing: gap of idle cycles once the burst runs out
    if (src_gaps) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(16, 1);
        gap = $urandom_range(5, 1);
        repeat (gap) begin
          @(negedge clk);
          item_bus.valid <= 1'b0;
        end
      end
    end
  endtask

  task automatic drive_ticks(int n, int stall_pct, int noise_pct, int stop_pct);
    repeat (n) send_tick(rand_tick(stall_pct, noise_pct, stop_pct));
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic drain_results();
    int waited;
    waited = 0;
    @(negedge clk);
    item_bus.valid <= 1'b0;
    while (expected_results.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    if (expected_results.size() != 0) begin
      flag_mismatch($sformatf("%0d results never arrived", expected_results.size()));
      expected_results.delete();
    end
    // pipeline is two deep; give it a few more edges
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(reg_idx_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      REG_MIN_COMMAND_SPEED:    shadow_cfg.min_command_speed    = val[14:0];
      REG_STALL_SPEED_LIMIT:    shadow_cfg.stall_speed_limit    = val[14:0];
      REG_STALL_CURRENT_LIMIT:  shadow_cfg.stall_current_limit  = val[14:0];
      REG_STARTUP_IGNORE_TICKS: shadow_cfg.startup_ignore_ticks = val;
      REG_DETECT_TICKS:         shadow_cfg.detect_ticks         = val;
      REG_REVERSE_TICKS:        shadow_cfg.reverse_ticks        = val;
      REG_RECOVERY_TICKS:       shadow_cfg.recovery_ticks       = val;
      REG_MAX_RETRIES:          shadow_cfg.max_retries          = val[7:0];
      default: ;
    endcase
  endtask

  // Write all eight registers back to back; unused upper data bits get
  // random values, the block must ignore them
  task automatic load_settings(cfg_t s);
    put_reg(REG_MIN_COMMAND_SPEED,    {1'($urandom), s.min_command_speed});
    put_reg(REG_STALL_SPEED_LIMIT,    {1'($urandom), s.stall_speed_limit});
    put_reg(REG_STALL_CURRENT_LIMIT,  {1'($urandom), s.stall_current_limit});
    put_reg(REG_STARTUP_IGNORE_TICKS, s.startup_ignore_ticks);
    put_reg(REG_DETECT_TICKS,         s.detect_ticks);
    put_reg(REG_REVERSE_TICKS,        s.reverse_ticks);
    put_reg(REG_RECOVERY_TICKS,       s.recovery_ticks);
    put_reg(REG_MAX_RETRIES,          {8'($urandom), s.max_retries});
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
    settings_loaded++;
  endtask

  // Short windows so jams, reverses and lockouts happen often
  function automatic cfg_t pick_settings();
    cfg_t s;
    s.min_command_speed    = 15'($urandom_range(600, 0));
    s.stall_speed_limit    = 15'($urandom_range(400, 1));
    s.stall_current_limit  = 15'($urandom_range(20000, 0));
    s.startup_ignore_ticks = 16'($urandom_range(6, 0));
    s.detect_ticks         = 16'($urandom_range(6, 0));
    s.reverse_ticks        = 16'($urandom_range(5, 0));
    s.recovery_ticks       = 16'($urandom_range(5, 0));
    s.max_retries          = 8'($urandom_range(4, 0));
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: ready changes on the falling edge, results checked on the rising
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    case (sink_style)
      SINK_RANDOM: result_bus.ready <= ($urandom_range(2) != 0);
      SINK_PATTERN: begin
        sink_pattern     <= {sink_pattern[6:0], sink_pattern[7]};
        result_bus.ready <= sink_pattern[0];
      end
      default: result_bus.ready <= 1'b1;
    endcase
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
      if (expected_results.size() == 0) begin
        flag_mismatch("result with no request outstanding");
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (result_bus.speed_command !== want.speed_command)
          flag_mismatch($sformatf("speed_command %0d, expected %0d",
                                  result_bus.speed_command, want.speed_command));
        if (result_bus.phase !== want.phase)
          flag_mismatch($sformatf("phase %0d, expected %s", result_bus.phase,
                                  want.phase.name()));
        if (result_bus.clear_loop !== want.clear_loop)
          flag_mismatch($sformatf("clear_loop %0b, expected %0b",
                                  result_bus.clear_loop, want.clear_loop));
        if (result_bus.retries !== want.retries)
          flag_mismatch($sformatf("retries %0d, expected %0d",
                                  result_bus.retries, want.retries));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked ticks: stop request, command at and below the minimum, the
  // -32768 magnitudes, stall boundaries, invalid feedback, jam on the first
  // stalled tick, lockout with no retries allowed, and leaving the lock.
  task automatic test_directed_cases();
    cfg_t s;
    s = '{min_command_speed: 15'd256, stall_speed_limit: 15'd128,
          stall_current_limit: 15'd32766, startup_ignore_ticks: 16'd1,
          detect_ticks: 16'd0, reverse_ticks: 16'd1, recovery_ticks: 16'd0,
          max_retries: 8'd0};
    src_gaps   = 1'b0;
    sink_style = SINK_OPEN;
    load_settings(s);
    send_tick(tick_of(1'b0, 16384, 0, 32767, 1'b1));       // stop request
    send_tick(tick_of(1'b1, 255, 0, 32767, 1'b1));         // just under minimum
    send_tick(tick_of(1'b1, -256, 0, 0, 1'b1));            // exactly minimum, startup
    send_tick(tick_of(1'b1, 32767, 0, -32768, 1'b0));      // feedback invalid
    send_tick(tick_of(1'b1, 32767, -32768, -32768, 1'b1)); // speed magnitude 32768
    send_tick(tick_of(1'b1, 32767, 127, 32767, 1'b1));     // stalled: jam at once
    send_tick(tick_of(1'b1, 1000, 0, 0, 1'b1));            // reverse
    send_tick(tick_of(1'b1, 1000, 0, 0, 1'b1));            // reverse done
    send_tick(tick_of(1'b1, 1000, 0, 0, 1'b1));            // recovery: lock
    send_tick(tick_of(1'b1, 1000, 0, 32767, 1'b1));        // locked holds
    send_tick(tick_of(1'b1, -32768, 0, 0, 1'b0));          // locked holds
    send_tick(tick_of(1'b0, -32768, 0, 0, 1'b0));          // stop leaves lock
    send_tick(tick_of(1'b1, -32768, 0, 0, 1'b1));          // startup
    send_tick(tick_of(1'b1, -32768, -128, 32767, 1'b1));   // speed at limit: clean
    send_tick(tick_of(1'b1, -32768, 0, 32766, 1'b1));      // current at limit: clean
    send_tick(tick_of(1'b1, -32768, -127, -32768, 1'b1));  // saturated current: jam
    send_tick(tick_of(1'b1, 512, 0, 0, 1'b1));
    send_tick(tick_of(1'b1, 512, 0, 0, 1'b1));
    send_tick(tick_of(1'b1, 512, 0, 0, 1'b1));             // lock again
    send_tick(tick_of(1'b1, -255, 0, 0, 1'b1));            // small negative command
    drain_results();
  endtask

  // Every register at its low end, then at its high end
  task automatic test_setting_extremes();
    cfg_t s;
    src_gaps   = 1'b1;
    sink_style = SINK_RANDOM;
    s = '0;
    load_settings(s);
    drive_ticks(12, 60, 20, 5);
    drain_results();
    s = '{min_command_speed: 15'h7FFF, stall_speed_limit: 15'h7FFF,
          stall_current_limit: 15'h7FFF, startup_ignore_ticks: 16'hFFFF,
          detect_ticks: 16'hFFFF, reverse_ticks: 16'hFFFF, recovery_ticks: 16'hFFFF,
          max_retries: 8'hFF};
    load_settings(s);
    drive_ticks(12, 60, 20, 5);
    drain_results();
  endtask

  // One jam, back to idle, then a long clean run must clear the retry count
  task automatic test_clean_run_clears_retries();
    cfg_t s;
    s = '{min_command_speed: 15'd256, stall_speed_limit: 15'd128,
          stall_current_limit: 15'd8000, startup_ignore_ticks: 16'd0,
          detect_ticks: 16'd0, reverse_ticks: 16'd0, recovery_ticks: 16'd0,
          max_retries: 8'd10};
    src_gaps   = 1'b1;
    sink_style = SINK_PATTERN;
    load_settings(s);
    drive_ticks(3, 100, 0, 0);
    drive_ticks(CLEAN_RESET_TICKS_DEF + 2, 0, 0, 0);
    drive_ticks(6, 100, 0, 0);
    drain_results();
  endtask

  // Jam on every third tick until the retry count reaches max_retries and locks
  task automatic test_retry_pileup();
    cfg_t s;
    s = '{min_command_speed: 15'd256, stall_speed_limit: 15'h7FFF,
          stall_current_limit: 15'd0, startup_ignore_ticks: 16'd0,
          detect_ticks: 16'd0, reverse_ticks: 16'd0, recovery_ticks: 16'd0,
          max_retries: 8'd10};
    src_gaps   = 1'b0;
    sink_style = SINK_OPEN;
    load_settings(s);
    drive_ticks(3 * 10 + 6, 100, 0, 0);
    drain_results();
  endtask

  // Random settings per phase; mostly stall-heavy well-formed ticks
  task automatic test_random_traffic();
    repeat (3) begin
      src_gaps   = ($urandom_range(3) != 0);
      sink_style = sink_style_t'($urandom_range(2));
      load_settings(pick_settings());
      drive_ticks(15, $urandom_range(90, 40), 8, 3);
      drain_results();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    // all inputs known from time zero, reset held high before the tests start
    rst                     = 1'b1;
    item_bus.valid          = 1'b0;
    item_bus.mode           = 1'b0;
    item_bus.forward_speed  = '0;
    item_bus.measured_speed = '0;
    item_bus.motor_current  = '0;
    item_bus.measure_valid  = 1'b0;
    result_bus.ready        = 1'b0;
    cfg_bus.valid           = 1'b0;
    cfg_bus.index           = REG_MIN_COMMAND_SPEED;
    cfg_bus.data            = '0;
    sink_style              = SINK_OPEN;
    sink_pattern            = 8'b1101_0110;
    src_gaps                = 1'b0;
    burst_left              = 0;
    mismatch_count          = 0;
    ticks_sent              = 0;
    results_checked         = 0;
    settings_loaded         = 0;
    jams_seen               = 0;
    lockouts_seen           = 0;
    peak_retries            = 0;

    shadow_cfg = '{min_command_speed: MIN_COMMAND_SPEED_RST,
                   stall_speed_limit: STALL_SPEED_LIMIT_RST,
                   stall_current_limit: STALL_CURRENT_LIMIT_RST,
                   startup_ignore_ticks: STARTUP_IGNORE_TICKS_RST,
                   detect_ticks: DETECT_TICKS_RST,
                   reverse_ticks: REVERSE_TICKS_RST,
                   recovery_ticks: RECOVERY_TICKS_RST,
                   max_retries: MAX_RETRIES_RST};
    clear_feeder_state();

    repeat (8) @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(negedge clk);

    test_directed_cases();
    test_setting_extremes();
    test_clean_run_clears_retries();
    test_retry_pileup();
    test_random_traffic();

    $display("Summary: %0d ticks, %0d results checked, %0d register settings.",
             ticks_sent, results_checked, settings_loaded);
    $display("Summary: %0d jams, %0d lockouts, highest retry count %0d.",
             jams_seen, lockouts_seen, peak_retries);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("Timeout with %0d results outstanding", expected_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
